FILE: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int TREE_LEVELS = 10;
  localparam int NODE_W     = TREE_LEVELS;
  localparam int LVL_W      = 4;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int WORDS      = (1 << TREE_LEVELS) / WORD_W;
  localparam int ADDR_W     = $clog2(WORDS);
  localparam int SIZE_W     = 31;
  localparam int NEED_W     = 32;
  localparam int BUCKET_W   = 17;
  localparam int TOTAL_W    = 26;
  localparam int OFF_W      = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(TREE_LEVELS - 1);
  localparam logic [NEED_W-1:0] HEADER_BYTES = NEED_W'(4);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET = CFG_IDX_W'(1);

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] alloc_size;
    logic [NODE_W-1:0] free_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [NODE_W-1:0]  block_index;
    logic [LVL_W-1:0]   block_level;
    logic [OFF_W-1:0]   block_offset;
    logic [TOTAL_W-1:0] block_bytes;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [NODE_W-1:0] idx;
    logic [LVL_W-1:0]  level;
    logic              info;
  } done_t;

endpackage

FILE: hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Request sequencer: clears, scans, splits and merges the free bitmap.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  in_t                in_data,
  input  logic [LVL_W-1:0]   eff_lvl,
  input  logic [TOTAL_W-1:0] total,
  output logic               busy,
  output done_t              done,
  output logic               we,
  output logic [ADDR_W-1:0]  waddr,
  output logic [WORD_W-1:0]  wdata,
  output logic [ADDR_W-1:0]  raddr,
  input  logic [WORD_W-1:0]  rdata
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CLR  = 10'b0000000010,
    S_LVL  = 10'b0000000100,
    S_SRD  = 10'b0000001000,
    S_SCK  = 10'b0000010000,
    S_PRD  = 10'b0000100000,
    S_PWR  = 10'b0001000000,
    S_FRD  = 10'b0010000000,
    S_FWR  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   w_r, w_nxt;
  logic [LVL_W-1:0]    d_r, d_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [NODE_W-1:0]   n_r, n_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [1:0]          st_r, st_nxt;
  logic [NODE_W-1:0]   ridx_r, ridx_nxt;
  logic [LVL_W-1:0]    rlvl_r, rlvl_nxt;
  logic                rinfo_r, rinfo_nxt;

  logic [WORD_W-1:0]   mask, hits, nbit, sbit;
  logic                hit;
  logic [BIT_W-1:0]    hb;
  logic [NODE_W:0]     lim, fn;
  logic [NODE_W-1:0]   hi_n, fnd_n;
  logic [LVL_W-1:0]    fmsb;
  logic [NEED_W-1:0]   need_in;
  logic [TOTAL_W-1:0]  tsh;

  function automatic logic [ADDR_W-1:0] lo_word(input logic [LVL_W-1:0] v);
    logic [NODE_W-1:0] t;
    t = NODE_W'(1) << v;
    return t[NODE_W-1:BIT_W];
  endfunction

  always_comb begin
    hi_n = NODE_W'((11'd2 << d_r) - 11'd1);
    for (int i = 0; i < WORD_W; i++) begin
      mask[i] = (d_r >= LVL_W'(BIT_W)) || ((i >> d_r) == 1);
    end
    hits = rdata & mask;
    hit  = 1'b0;
    hb   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit = 1'b1;
        hb  = BIT_W'(i);
      end
    end
    fnd_n = {w_r, hb};
    nbit  = WORD_W'(1) << n_r[BIT_W-1:0];
    sbit  = WORD_W'(1) << (n_r[BIT_W-1:0] ^ BIT_W'(1));
    lim   = (11'd2 << eff_lvl) - 11'd1;
    fn    = {1'b0, in_data.free_index} + 11'd1;
    fmsb  = '0;
    for (int i = 0; i <= NODE_W; i++) begin
      if (fn[i]) begin
        fmsb = LVL_W'(i);
      end
    end
    need_in = {1'b0, in_data.alloc_size} + HEADER_BYTES;
    tsh     = total >> (lvl_r + LVL_W'(1));
  end

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    d_nxt     = d_r;
    lvl_nxt   = lvl_r;
    n_nxt     = n_r;
    need_nxt  = need_r;
    st_nxt    = st_r;
    ridx_nxt  = ridx_r;
    rlvl_nxt  = rlvl_r;
    rinfo_nxt = rinfo_r;
    we        = 1'b0;
    waddr     = w_r;
    wdata     = '0;
    raddr     = w_r;
    case (state_r)
      S_CLR: begin
        we    = 1'b1;
        wdata = (w_r == '0) ? WORD_W'(2) : '0;
        w_nxt = w_r + ADDR_W'(1);
        if (w_r == ADDR_W'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          st_nxt    = ST_OK;
          rinfo_nxt = 1'b1;
          if (in_data.req_type == REQ_ALLOC) begin
            need_nxt = need_in;
            lvl_nxt  = '0;
            if (need_in > NEED_W'(total)) begin
              st_nxt    = ST_OOM;
              ridx_nxt  = '0;
              rinfo_nxt = 1'b0;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_LVL;
            end
          end else begin
            ridx_nxt = in_data.free_index;
            if (fn > lim) begin
              st_nxt    = ST_BAD;
              rinfo_nxt = 1'b0;
              state_nxt = S_DONE;
            end else begin
              n_nxt     = fn[NODE_W-1:0];
              rlvl_nxt  = fmsb;
              state_nxt = S_FRD;
            end
          end
        end
      end
      S_LVL: begin
        if (lvl_r < eff_lvl && need_r <= NEED_W'(tsh)) begin
          lvl_nxt = lvl_r + LVL_W'(1);
        end else begin
          d_nxt     = lvl_r;
          rlvl_nxt  = lvl_r;
          w_nxt     = lo_word(lvl_r);
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        state_nxt = S_SCK;
      end
      S_SCK: begin
        if (hit) begin
          we       = 1'b1;
          wdata    = rdata & ~(WORD_W'(1) << hb);
          ridx_nxt = fnd_n - NODE_W'(1);
          if (d_r == lvl_r) begin
            state_nxt = S_DONE;
          end else begin
            n_nxt     = fnd_n << 1;
            w_nxt     = fnd_n[NODE_W-2:BIT_W-1];
            state_nxt = S_PRD;
          end
        end else if (w_r == hi_n[NODE_W-1:BIT_W]) begin
          if (d_r == '0) begin
            st_nxt    = ST_OOM;
            ridx_nxt  = '0;
            rinfo_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            d_nxt     = d_r - LVL_W'(1);
            w_nxt     = lo_word(d_r - LVL_W'(1));
            state_nxt = S_SRD;
          end
        end else begin
          w_nxt     = w_r + ADDR_W'(1);
          state_nxt = S_SRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PWR;
      end
      S_PWR: begin
        we       = 1'b1;
        wdata    = rdata | sbit;
        d_nxt    = d_r + LVL_W'(1);
        ridx_nxt = n_r - NODE_W'(1);
        if (d_r + LVL_W'(1) == lvl_r) begin
          state_nxt = S_DONE;
        end else begin
          n_nxt     = n_r << 1;
          w_nxt     = n_r[NODE_W-2:BIT_W-1];
          state_nxt = S_PRD;
        end
      end
      S_FRD: begin
        w_nxt     = n_r[NODE_W-1:BIT_W];
        raddr     = n_r[NODE_W-1:BIT_W];
        state_nxt = S_FWR;
      end
      S_FWR: begin
        we = 1'b1;
        if (n_r != NODE_W'(1) && (rdata & sbit) != '0) begin
          wdata     = rdata & ~(nbit | sbit);
          n_nxt     = n_r >> 1;
          state_nxt = S_FRD;
        end else begin
          wdata     = rdata | nbit;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      w_r     <= '0;
    end else begin
      state_r <= state_nxt;
      w_r     <= w_nxt;
    end
    d_r     <= d_nxt;
    lvl_r   <= lvl_nxt;
    n_r     <= n_nxt;
    need_r  <= need_nxt;
    st_r    <= st_nxt;
    ridx_r  <= ridx_nxt;
    rlvl_r  <= rlvl_nxt;
    rinfo_r <= rinfo_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign done.valid = (state_r == S_DONE);
  assign done.status = st_r;
  assign done.idx    = ridx_r;
  assign done.level  = rinfo_r ? rlvl_r : '0;
  assign done.info   = rinfo_r;

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |=> !done.valid)
    else $error("done held for more than one cycle");
  a_idle_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && state_r == S_IDLE))
    else $error("bitmap written while idle");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> state_r == S_CLR)
    else $error("reset did not start the clearing pass");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule

FILE: hw/rtl/buddy_block_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Buddy allocator over a heap-ordered free bitmap held in a word RAM.
// ----------------------------------------------------------------------------
// channel  ports                                     beat taken when
// in       start, busy, in_data                      start && !busy
// out      out_valid, out_data                       out_valid (one cycle)
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// Busy per beat: an allocate steps through the levels, scans bitmap words and
// splits; a free merges step by step; an oversize request or a bad index goes
// straight to done. Each bitmap change is a RAM read-modify-write. The result
// strobes as busy falls. After reset a clearing pass over the 32 bitmap words
// holds busy high. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top import bba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_data,
  output logic                  out_valid,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LVL_W-1:0]    lvl_cfg_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic [LVL_W-1:0]    eff_lvl;
  logic [TOTAL_W-1:0]  total, bytes;
  logic [NODE_W:0]     k;
  logic [TOTAL_W+NODE_W-1:0] prod;
  done_t               done;
  logic                out_valid_r;
  out_t                out_r, out_nxt;
  logic                we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [WORD_W-1:0]   wdata, rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_cfg_r <= LVL_W'(9);
      bucket_r  <= BUCKET_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVELS: lvl_cfg_r <= cfg_data[LVL_W-1:0];
        CFG_BUCKET: bucket_r  <= cfg_data[BUCKET_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_lvl = (lvl_cfg_r > LVL_MAX) ? LVL_MAX : lvl_cfg_r;
  assign total   = TOTAL_W'(bucket_r) << eff_lvl;

  bba_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .eff_lvl (eff_lvl),
    .total   (total),
    .busy    (busy),
    .done    (done),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  bba_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    bytes = total >> done.level;
    k     = {1'b0, done.idx} + 11'd1 - (11'd1 << done.level);
    prod  = bytes * k[NODE_W-1:0];
    out_nxt.status      = done.status;
    out_nxt.block_index = done.idx;
    out_nxt.block_level = done.level;
    out_nxt.block_offset = done.info ? prod[OFF_W-1:0] : '0;
    out_nxt.block_bytes  = done.info ? bytes : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done.valid;
    end
    if (done.valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Buddy block allocator testbench: directed and random alloc/free traffic over
// several region settings, checked against a bitmap predictor kept in step
// with every accepted request.
// ----------------------------------------------------------------------------
module tb_top import bba_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = (1 << TREE_LEVELS) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 160;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_data;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  buddy_block_allocator_top DUT (.*);

  bit          free_map [NODES];
  int unsigned lvl_cfg;
  longint      bucket_cfg;
  out_t        pending_results[$];
  int          live_blocks[$];
  int          errors;
  int          sent;
  int          checked;
  int          idle_pct;
  longint      cycles;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, checked);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected result, index %0d", out_data.block_index);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status != want.status) report("status", out_data.status, want.status);
        if (out_data.block_index != want.block_index)
          report("block_index", out_data.block_index, want.block_index);
        if (out_data.block_level != want.block_level)
          report("block_level", out_data.block_level, want.block_level);
        if (out_data.block_offset != want.block_offset)
          report("block_offset", out_data.block_offset, want.block_offset);
        if (out_data.block_bytes != want.block_bytes)
          report("block_bytes", out_data.block_bytes, want.block_bytes);
      end
      checked++;
    end
  end

  function automatic int unsigned depth_of(int unsigned node);
    int unsigned v = 0;
    int unsigned n = node + 1;
    while (n > 1) begin
      n >>= 1;
      v++;
    end
    return v;
  endfunction

  function automatic int unsigned eff_levels();
    return (lvl_cfg > TREE_LEVELS - 1) ? TREE_LEVELS - 1 : lvl_cfg;
  endfunction

  function automatic longint region_bytes();
    return bucket_cfg << eff_levels();
  endfunction

  function automatic out_t block_result(logic [1:0] st, int unsigned node, bit info);
    out_t r;
    longint bytes;
    int unsigned v;
    r = '0;
    r.status = st;
    r.block_index = node[NODE_W-1:0];
    if (info) begin
      v = depth_of(node);
      bytes = region_bytes() >> v;
      r.block_level = v[LVL_W-1:0];
      r.block_bytes = bytes[TOTAL_W-1:0];
      r.block_offset = OFF_W'(bytes * longint'(node + 1 - (1 << v)));
    end
    return r;
  endfunction

  // advances the bitmap and returns the expected result
  function automatic out_t allocate_or_free(in_t req);
    int unsigned lv, tgt, d, node, cur, sib, lim;
    longint need, q, total;
    int found;
    lv = eff_levels();
    total = region_bytes();
    if (req.req_type == REQ_ALLOC) begin
      need = longint'(req.alloc_size) + 4;
      if (need > total) return block_result(ST_OOM, 0, 0);
      q = total / need;
      tgt = 0;
      while (q > 1) begin
        q >>= 1;
        tgt++;
      end
      if (tgt > lv) tgt = lv;
      d = tgt;
      found = -1;
      forever begin
        for (int i = (1 << d) - 1; i < (1 << (d + 1)) - 1; i++) begin
          if (free_map[i]) begin
            found = i;
            break;
          end
        end
        if (found >= 0 || d == 0) break;
        d--;
      end
      if (found < 0) return block_result(ST_OOM, 0, 0);
      node = found;
      free_map[node] = 0;
      while (d < tgt) begin
        free_map[2 * node + 2] = 1;
        node = 2 * node + 1;
        d++;
      end
      return block_result(ST_OK, node, 1);
    end
    node = req.free_index;
    lim = (1 << (lv + 1)) - 1;
    if (node >= lim) return block_result(ST_BAD, node, 0);
    cur = node;
    forever begin
      free_map[cur] = 1;
      if (cur == 0) break;
      sib = cur[0] ? cur + 1 : cur - 1;
      if (!free_map[sib]) break;
      free_map[cur] = 0;
      free_map[sib] = 0;
      cur = (cur - 1) / 2;
    end
    return block_result(ST_OK, node, 1);
  endfunction

  // leaves start high on return; the next call or end_burst settles it
  task automatic send_request(input in_t req);
    out_t exp_r;
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0 && start) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    exp_r = allocate_or_free(req);
    pending_results.push_back(exp_r);
    if (req.req_type == REQ_ALLOC && exp_r.status == ST_OK)
      live_blocks.push_back(exp_r.block_index);
    sent++;
  endtask

  task automatic end_burst();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_LEVELS) lvl_cfg = val & 32'hF;
    else if (idx == CFG_BUCKET) bucket_cfg = val & 32'h1FFFF;
  endtask

  task automatic set_region(input int unsigned lv, input int unsigned bucket);
    write_reg(CFG_LEVELS, lv);
    write_reg(CFG_BUCKET, bucket);
  endtask

  function automatic in_t alloc_req(input longint size);
    in_t r;
    r = '0;
    r.req_type = REQ_ALLOC;
    r.alloc_size = size[SIZE_W-1:0];
    r.free_index = NODE_W'($urandom);
    return r;
  endfunction

  function automatic in_t free_req(input int unsigned node);
    in_t r;
    r = '0;
    r.req_type = REQ_FREE;
    r.alloc_size = SIZE_W'($urandom);
    r.free_index = node[NODE_W-1:0];
    return r;
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    set_region(3, 4);
    send_request(alloc_req(32'h7FFF_FFFF));
    send_request(alloc_req(28));
    send_request(alloc_req(0));
    send_request(free_req(0));
    for (int i = 0; i < 9; i++) send_request(alloc_req(0));
    send_request(free_req(8));
    send_request(free_req(7));
    send_request(free_req(7));
    send_request(free_req(14));
    send_request(free_req(15));
    send_request(free_req(1023));
    send_request(alloc_req(12));
    send_request(alloc_req(29));
    end_burst();
    set_region(0, 4);
    send_request(free_req(0));
    send_request(alloc_req(0));
    send_request(free_req(1));
    end_burst();
    live_blocks.delete();
  endtask

  task automatic random_traffic(input int n);
    longint total, blk;
    int k;
    for (int i = 0; i < n; i++) begin
      total = region_bytes();
      if ($urandom_range(99) < 8) begin
        send_request(alloc_req({$urandom} & 32'h7FFF_FFFF));
      end else if ($urandom_range(99) < 6) begin
        send_request(free_req($urandom_range(1023)));
      end else if (live_blocks.size() != 0 && $urandom_range(99) < 45) begin
        k = $urandom_range(live_blocks.size() - 1);
        send_request(free_req(live_blocks[k]));
        live_blocks.delete(k);
      end else begin
        blk = total >> $urandom_range(eff_levels());
        if (blk > 4) send_request(alloc_req(longint'($urandom_range(int'(blk - 4)))));
        else send_request(alloc_req(0));
      end
    end
    end_burst();
  endtask

  task automatic test_random_regions();
    int unsigned lv_set[6] = '{9, 0, 9, 4, 8, 2};
    int unsigned bk_set[6] = '{64, 65536, 65536, 4, 37, 1000};
    int unsigned pct_set[4] = '{0, 69, 20, 69};
    for (int s = 0; s < 6; s++) begin
      set_region(lv_set[s], bk_set[s]);
      live_blocks.delete();
      for (int p = 0; p < 4; p++) begin
        idle_pct = pct_set[p];
        random_traffic(75);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    errors = 0;
    sent = 0;
    checked = 0;
    idle_pct = 0;
    foreach (free_map[i]) free_map[i] = 0;
    free_map[0] = 1;
    lvl_cfg = 9;
    bucket_cfg = 64;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_regions();
    $display("%0d requests sent, %0d results checked", sent, checked);
    $display("region settings: levels 0..9, bucket 4..65536, idle 0/20/69 pct");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/buddy_block_allocator_top.sv
sim/tb_top.sv
